>>> hw/rtl/double_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Double hash table assertion macros
// Immediate-cycle and next-cycle implications, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define DHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, codes and defaults of the double hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package dht_pkg;

  localparam int CMD_W           = 2;
  localparam int KEY_PORT_W      = 32;
  localparam int VALUE_PORT_W    = 32;
  localparam int HASH_W          = 8;
  localparam int STATUS_W        = 2;
  localparam int COUNT_PORT_W    = 9;
  localparam int MARK_W          = 2;

  localparam int DEPTH_DEFAULT       = 256;
  localparam int KEY_WIDTH_DEFAULT   = 32;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Command codes; code 3 is unused and answers with STAT_NOT_FOUND.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_PRESENT   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_NO_ROOM   = 2'd3
  } result_t;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_VACATED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_CHECK
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;
    logic    clear_wr;
    logic    rd;
    logic    advance;
    logic    commit_insert;
    logic    commit_remove;
    logic    finish;
    logic    with_value;
    result_t stat_code;
  } dht_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic is_lookup;
    logic is_insert;
    logic is_remove;
    logic table_full;
    logic mark_empty;
    logic mark_vacated;
    logic key_match;
    logic last_probe;
    logic free_found;
  } dht_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/double_hash_table.sv
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressed key/value table probed by double hashing.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_cmd (0 lookup, 1 insert, 2 remove), in_key,
//   in_value_in, in_hash_first and in_hash_step with start high; the
//   transaction is taken at the rising edge where start is high and busy low.
//   Probe i reads slot (in_hash_first + i*in_hash_step) mod TABLE_DEPTH.
//   Result channel: out_valid pulses for one cycle with out_status,
//   out_value_out and out_entries_in_use. The receiver cannot stall, so the
//   result must be captured in that cycle; it is never repeated.
//   Probe walk: a probe reads a slot through the single RAM read port in
//   ST_ISSUE and compares it in ST_CHECK, a walk taking 1 to TABLE_DEPTH
//   probes; an insert into a full table or an unused command code finishes
//   in ST_ISSUE. The finish is registered into the result strobe, and the
//   next command can be accepted in the strobe cycle.
//   Reset: a clearing pass writes every slot empty, one per cycle, and holds
//   busy high until the last slot is written after rst_n rises.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_hash_table_assert.svh"

module double_hash_table #(
  parameter int TABLE_DEPTH = dht_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = dht_pkg::KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = dht_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [dht_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [dht_pkg::KEY_PORT_W-1:0]    in_key,
  input  wire logic [dht_pkg::VALUE_PORT_W-1:0]  in_value_in,
  input  wire logic [dht_pkg::HASH_W-1:0]        in_hash_first,
  input  wire logic [dht_pkg::HASH_W-1:0]        in_hash_step,
  output logic                                   out_valid,
  output logic      [dht_pkg::STATUS_W-1:0]      out_status,
  output logic      [dht_pkg::VALUE_PORT_W-1:0]  out_value_out,
  output logic      [dht_pkg::COUNT_PORT_W-1:0]  out_entries_in_use
);

  import dht_pkg::*;

  dht_cmd_t   cmd;
  dht_flags_t flags;

  // Sequence the clearing pass and each probe walk.
  dht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  // Hold the transaction, walk the slots and drive the result strobe.
  dht_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .flags              (flags),
    .in_cmd             (in_cmd),
    .in_key             (in_key),
    .in_value_in        (in_value_in),
    .in_hash_first      (in_hash_first),
    .in_hash_step       (in_hash_step),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_value_out      (out_value_out),
    .out_entries_in_use (out_entries_in_use)
  );

  // An accepted transaction must occupy the block in the following cycle.
  `DHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")

  // A strobe cycle is spent in ST_IDLE, where no command finishes, so results never come back to back.
  `DHT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe lasted two cycles")

  // A result only follows a cycle of work.
  `DHT_ASSERT_NOW(a_result_after_work, out_valid, $past(busy), "result without work")

endmodule

`default_nettype wire

>>> hw/rtl/dht_ram.sv
// ----------------------------------------------------------------------------
// dht_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/dht_datapath.sv
// ----------------------------------------------------------------------------
// dht_datapath
// Command capture, probe walk, slot RAM, occupancy count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_datapath #(
  parameter int TABLE_DEPTH = dht_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = dht_pkg::KEY_WIDTH_DEFAULT,
  parameter int VALUE_WIDTH = dht_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dht_pkg::dht_cmd_t                 cmd,
  output dht_pkg::dht_flags_t                    flags,
  input  wire logic [dht_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [dht_pkg::KEY_PORT_W-1:0]    in_key,
  input  wire logic [dht_pkg::VALUE_PORT_W-1:0]  in_value_in,
  input  wire logic [dht_pkg::HASH_W-1:0]        in_hash_first,
  input  wire logic [dht_pkg::HASH_W-1:0]        in_hash_step,
  output logic                                   out_valid,
  output logic      [dht_pkg::STATUS_W-1:0]      out_status,
  output logic      [dht_pkg::VALUE_PORT_W-1:0]  out_value_out,
  output logic      [dht_pkg::COUNT_PORT_W-1:0]  out_entries_in_use
);

  import dht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_W = MARK_W + KEY_WIDTH + VALUE_WIDTH;

  // Captured command
  logic [CMD_W-1:0]       op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [HASH_W-1:0]      step_r;

  // Probe walk
  logic [IDX_W-1:0] probe_addr_r;
  logic [IDX_W-1:0] probe_cnt_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_slot_r;
  logic [IDX_W-1:0] clear_addr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Results
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [VALUE_PORT_W-1:0] out_value_r;
  logic [COUNT_PORT_W-1:0] out_count_r;

  // RAM
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [RAM_W-1:0] wr_data;
  logic [RAM_W-1:0] rd_data;

  logic [MARK_W-1:0]      rd_mark;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  assign rd_mark = rd_data[RAM_W-1 -: MARK_W];
  assign rd_key  = rd_data[VALUE_WIDTH +: KEY_WIDTH];
  assign rd_val  = rd_data[0 +: VALUE_WIDTH];

  always_comb begin
    wr_en   = cmd.clear_wr | cmd.commit_insert | cmd.commit_remove;
    wr_addr = probe_addr_r;
    wr_data = {MARK_VACATED, rd_data[RAM_W-MARK_W-1:0]};
    if (cmd.clear_wr) begin
      wr_addr = clear_addr_r;
      wr_data = {MARK_EMPTY, {(RAM_W-MARK_W){1'b0}}};
    end else if (cmd.commit_insert) begin
      wr_addr = free_found_r ? free_slot_r : probe_addr_r;
      wr_data = {MARK_USED, key_r, value_r};
    end
  end

  dht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (probe_addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.commit_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.commit_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_cmd;
      key_r        <= KEY_WIDTH'(in_key);
      value_r      <= VALUE_WIDTH'(in_value_in);
      step_r       <= in_hash_step;
      probe_addr_r <= IDX_W'(in_hash_first);
      probe_cnt_r  <= '0;
      free_found_r <= 1'b0;
    end else if (cmd.advance) begin
      probe_addr_r <= probe_addr_r + IDX_W'(step_r);
      probe_cnt_r  <= probe_cnt_r + IDX_W'(1);
      if ((rd_mark == MARK_VACATED) && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= probe_addr_r;
      end
    end
    if (cmd.finish) begin
      out_status_r <= cmd.stat_code;
      out_value_r  <= cmd.with_value ? VALUE_PORT_W'(rd_val) : '0;
      out_count_r  <= COUNT_PORT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_addr_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clear_addr_r <= clear_addr_r + IDX_W'(1);
      end
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_comb begin
    flags.clear_last   = (clear_addr_r == IDX_W'(TABLE_DEPTH - 1));
    flags.is_lookup    = (op_r == CMD_LOOKUP);
    flags.is_insert    = (op_r == CMD_INSERT);
    flags.is_remove    = (op_r == CMD_REMOVE);
    flags.table_full   = (count_r == CNT_W'(TABLE_DEPTH));
    flags.mark_empty   = (rd_mark == MARK_EMPTY);
    flags.mark_vacated = (rd_mark == MARK_VACATED);
    flags.key_match    = (rd_mark == MARK_USED) && (rd_key == key_r);
    flags.last_probe   = (probe_cnt_r == IDX_W'(TABLE_DEPTH - 1));
    flags.free_found   = free_found_r;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value_out      = out_value_r;
  assign out_entries_in_use = out_count_r;

endmodule

`default_nettype wire

>>> hw/rtl/dht_ctrl.sv
// ----------------------------------------------------------------------------
// dht_ctrl
// Sequencer: clearing pass, command dispatch and a probe walk of ST_ISSUE and ST_CHECK.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dht_pkg::dht_flags_t flags,
  output dht_pkg::dht_cmd_t        cmd
);

  import dht_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   op_valid;
  logic   probe_stop;

  assign op_valid   = flags.is_lookup | flags.is_insert | flags.is_remove;
  assign probe_stop = flags.key_match | flags.mark_empty | flags.last_probe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (flags.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if ((flags.is_insert && flags.table_full) || !op_valid) state_nxt = ST_IDLE;
        else state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = probe_stop ? ST_IDLE : ST_ISSUE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.stat_code = STAT_NOT_FOUND;
    busy          = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_ISSUE: begin
        if (flags.is_insert && flags.table_full) begin
          cmd.finish    = 1'b1;
          cmd.stat_code = STAT_NO_ROOM;
        end else if (!op_valid) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      ST_CHECK: begin
        if (flags.key_match) begin
          cmd.finish = 1'b1;
          if (flags.is_insert) begin
            cmd.stat_code = STAT_PRESENT;
          end else begin
            cmd.stat_code     = STAT_DONE;
            cmd.with_value    = 1'b1;
            cmd.commit_remove = flags.is_remove;
          end
        end else if (flags.mark_empty ||
                     (flags.last_probe && (flags.free_found || flags.mark_vacated))) begin
          cmd.finish = 1'b1;
          if (flags.is_insert) begin
            cmd.commit_insert = 1'b1;
            cmd.stat_code     = STAT_DONE;
          end
        end else if (flags.last_probe) begin
          cmd.finish = 1'b1;
          if (flags.is_insert) cmd.stat_code = STAT_NO_ROOM;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
